### design/assert_macros.svh
// Assertion macros shared by the mecanum wheel speed mixer RTL.
// Needs nothing else; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/mwsm_pkg.sv
// Package for the mecanum wheel speed mixer: widths, register map, reset values
// and the structs that travel between the pipeline sections. Depends on nothing.
`timescale 1ns / 1ps

package mwsm_pkg;

   localparam int NumWheels = 4;
   localparam int SpeedW    = 16;             // command and wheel speed fields
   localparam int LimW      = 15;             // clamp and wheel limits
   localparam int RatioW    = 16;             // Q8.8 ratios
   localparam int FracW     = 8;              // fraction bits of Q8.8
   localparam int LinW      = 17;             // sum or difference of two speeds
   localparam int TurnW     = 32;             // turn rate times turn ratio
   localparam int SumW      = 33;             // Q8.8 wheel velocity
   localparam int ProdW     = 49;             // Q16.16 wheel speed
   localparam int MagW      = 32;             // integer wheel speed magnitude
   localparam int QuotW     = LimW;           // scaled magnitude
   localparam int NumW      = MagW + QuotW;   // scaling dividend
   localparam int DataW     = 32;
   localparam int AddrW     = 5;

   typedef enum logic [2:0] {
      REG_MAX_SIDEWAYS = 3'd0,
      REG_MAX_FORWARD  = 3'd1,
      REG_MAX_TURN     = 3'd2,
      REG_FRONT_RATIO  = 3'd3,
      REG_REAR_RATIO   = 3'd4,
      REG_RPM_RATIO    = 3'd5,
      REG_MAX_WHEEL    = 3'd6
   } mwsm_reg_type;

   localparam logic [LimW-1:0]   RstMaxSideways = 15'd500;
   localparam logic [LimW-1:0]   RstMaxForward  = 15'd500;
   localparam logic [LimW-1:0]   RstMaxTurn     = 15'd200;
   localparam logic [RatioW-1:0] RstFrontRatio  = 16'd1117;
   localparam logic [RatioW-1:0] RstRearRatio   = 16'd1117;
   localparam logic [RatioW-1:0] RstRpmRatio    = 16'd7276;
   localparam logic [LimW-1:0]   RstMaxWheel    = 15'd15000;

   typedef struct packed {
      logic [LimW-1:0]   max_sideways_speed;
      logic [LimW-1:0]   max_forward_speed;
      logic [LimW-1:0]   max_turn_rate;
      logic [RatioW-1:0] front_turn_ratio;
      logic [RatioW-1:0] rear_turn_ratio;
      logic [RatioW-1:0] rpm_per_speed;
      logic [LimW-1:0]   max_wheel_speed;
   } mwsm_cfg_type;

   typedef struct packed {
      logic [NumWheels-1:0][MagW-1:0] mag;
      logic [NumWheels-1:0]           neg;
   } mwsm_mag_type;

   typedef struct packed {
      logic [NumWheels-1:0][NumW-1:0] num;
      logic [MagW-1:0]                den;
      logic [NumWheels-1:0]           neg;
      logic                           scaled;
   } mwsm_div_in_type;

   typedef struct packed {
      logic [NumWheels-1:0][QuotW-1:0] quot;
      logic [NumWheels-1:0]            neg;
      logic                            scaled;
   } mwsm_div_out_type;

endpackage

### design/mecanum_wheel_speed_mixer.sv
// Top level of the mecanum wheel speed mixer; uses mwsm_pkg, mwsm_mix, mwsm_prep,
// mwsm_div and the macros in assert_macros.svh.
//
// A request carries one chassis command: sideways and forward speed in mm/s and a
// turn rate in deg/s. Each part is clamped to its limit, the parts are mixed into
// four mecanum wheel speeds in rpm, and if the largest magnitude exceeds
// max_wheel_speed all four are scaled by max_wheel_speed / largest (truncating
// toward zero) and rsp_was_scaled is set. Limits and Q8.8 ratios sit in seven
// registers on the APB port at byte addresses 0, 4, ... 24; write them only while
// no request is in flight. pready is always high and reads return the register.
// A request is taken at a clock edge with req_valid high and req_stall low, and a
// result likewise with rsp_valid high and rsp_stall low.
// The pipeline is 24 registers deep: 5 for clamp, mixing and the rpm product, 3 for
// the largest-magnitude tree and the scaling dividends, 15 for the divider (one
// quotient bit per stage) and the output register. One request enters every cycle
// while results are taken. When the receiver stalls, the output holds and earlier
// stages keep filling any empty slots; req_stall rises only once every stage holds
// an item. Synchronous reset empties the pipeline and loads the register reset values.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mecanum_wheel_speed_mixer
   import mwsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [SpeedW-1:0] req_sideways_speed,
   input  logic signed [SpeedW-1:0] req_forward_speed,
   input  logic signed [SpeedW-1:0] req_turn_rate,
   // Result channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [SpeedW-1:0] rsp_wheel_speed_0,
   output logic signed [SpeedW-1:0] rsp_wheel_speed_1,
   output logic signed [SpeedW-1:0] rsp_wheel_speed_2,
   output logic signed [SpeedW-1:0] rsp_wheel_speed_3,
   output logic                     rsp_was_scaled,
   // Register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [AddrW-1:0]         paddr,
   input  logic [DataW-1:0]         pwdata,
   output logic [DataW-1:0]         prdata,
   output logic                     pready
);

   mwsm_cfg_type     cfg_ff;
   mwsm_reg_type     reg_idx;

   logic             mix_valid, mix_stall;
   mwsm_mag_type     mix_data;
   logic             prep_valid, prep_stall;
   mwsm_div_in_type  prep_data;
   logic             div_valid, div_stall;
   mwsm_div_out_type div_data;

   logic             rsp_en;
   logic             rsp_valid_ff;
   logic             rsp_scaled_ff, rsp_scaled_in;
   logic [NumWheels-1:0][SpeedW-1:0] rsp_speed_ff, rsp_speed_in;
   logic             rsp_min_code;

   // Register file. Bits above a register's width are dropped on write, and
   // writes to the unused eighth slot do nothing.
   assign pready  = 1'b1;
   assign reg_idx = mwsm_reg_type'(paddr[AddrW-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_sideways_speed <= RstMaxSideways;
         cfg_ff.max_forward_speed  <= RstMaxForward;
         cfg_ff.max_turn_rate      <= RstMaxTurn;
         cfg_ff.front_turn_ratio   <= RstFrontRatio;
         cfg_ff.rear_turn_ratio    <= RstRearRatio;
         cfg_ff.rpm_per_speed      <= RstRpmRatio;
         cfg_ff.max_wheel_speed    <= RstMaxWheel;
      end else if (psel && penable && pwrite) begin
         case (reg_idx)
            REG_MAX_SIDEWAYS: cfg_ff.max_sideways_speed <= pwdata[LimW-1:0];
            REG_MAX_FORWARD:  cfg_ff.max_forward_speed  <= pwdata[LimW-1:0];
            REG_MAX_TURN:     cfg_ff.max_turn_rate      <= pwdata[LimW-1:0];
            REG_FRONT_RATIO:  cfg_ff.front_turn_ratio   <= pwdata[RatioW-1:0];
            REG_REAR_RATIO:   cfg_ff.rear_turn_ratio    <= pwdata[RatioW-1:0];
            REG_RPM_RATIO:    cfg_ff.rpm_per_speed      <= pwdata[RatioW-1:0];
            REG_MAX_WHEEL:    cfg_ff.max_wheel_speed    <= pwdata[LimW-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MAX_SIDEWAYS: prdata = {{(DataW - LimW){1'b0}}, cfg_ff.max_sideways_speed};
         REG_MAX_FORWARD:  prdata = {{(DataW - LimW){1'b0}}, cfg_ff.max_forward_speed};
         REG_MAX_TURN:     prdata = {{(DataW - LimW){1'b0}}, cfg_ff.max_turn_rate};
         REG_FRONT_RATIO:  prdata = {{(DataW - RatioW){1'b0}}, cfg_ff.front_turn_ratio};
         REG_REAR_RATIO:   prdata = {{(DataW - RatioW){1'b0}}, cfg_ff.rear_turn_ratio};
         REG_RPM_RATIO:    prdata = {{(DataW - RatioW){1'b0}}, cfg_ff.rpm_per_speed};
         REG_MAX_WHEEL:    prdata = {{(DataW - LimW){1'b0}}, cfg_ff.max_wheel_speed};
         default:          prdata = '0;
      endcase
   end

   // Clamp, mix and convert to rpm magnitudes.
   mwsm_mix u_mix (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_stall    (req_stall),
      .in_sideways (req_sideways_speed),
      .in_forward  (req_forward_speed),
      .in_turn     (req_turn_rate),
      .out_valid   (mix_valid),
      .out_stall   (mix_stall),
      .out_data    (mix_data)
   );

   // Find the largest magnitude and set up the scaling divisions.
   mwsm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mix_valid),
      .in_stall  (mix_stall),
      .in_data   (mix_data),
      .out_valid (prep_valid),
      .out_stall (prep_stall),
      .out_data  (prep_data)
   );

   // Four lanes of |w| * max_wheel_speed / largest, or |w| / 1 when unscaled.
   mwsm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_stall  (prep_stall),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_data  (div_data)
   );

   // Output register: the sign goes back on here. Magnitudes never exceed
   // 15 bits, so the 16-bit results cannot wrap.
   assign rsp_en    = !rsp_valid_ff || !rsp_stall;
   assign div_stall = !rsp_en;

   always_comb begin
      for (int i = 0; i < NumWheels; i++) begin
         rsp_speed_in[i] = div_data.neg[i] ? -{1'b0, div_data.quot[i]}
                                           : {1'b0, div_data.quot[i]};
      end
      rsp_scaled_in = div_data.scaled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_en) begin
         rsp_speed_ff  <= rsp_speed_in;
         rsp_scaled_ff <= rsp_scaled_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_wheel_speed_0 = rsp_speed_ff[0];
   assign rsp_wheel_speed_1 = rsp_speed_ff[1];
   assign rsp_wheel_speed_2 = rsp_speed_ff[2];
   assign rsp_wheel_speed_3 = rsp_speed_ff[3];
   assign rsp_was_scaled    = rsp_scaled_ff;

   // Set when any wheel shows the most negative 16-bit code.
   assign rsp_min_code = (rsp_wheel_speed_0 == 16'h8000) || (rsp_wheel_speed_1 == 16'h8000)
                      || (rsp_wheel_speed_2 == 16'h8000) || (rsp_wheel_speed_3 == 16'h8000);

   // With the output register empty every stage can advance, so nothing stalls.
   `ASSERT_IMPLIES(a_no_stall_when_out_empty, clock, reset, !rsp_valid, !req_stall)

   // Magnitudes come out of a 15-bit quotient, so the most negative code never shows.
   `ASSERT_IMPLIES(a_no_min_code, clock, reset, rsp_valid, !rsp_min_code)

   // Reset empties the output register by the next cycle.
   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)

endmodule

### design/mwsm_mix.sv
// Front section of the mixer: clamp, mix with the turn ratios, scale to rpm and
// split into sign and magnitude over five stages. Depends on mwsm_pkg.
`timescale 1ns / 1ps

module mwsm_mix
   import mwsm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mwsm_cfg_type             cfg,
   input  logic                     in_valid,
   output logic                     in_stall,
   input  logic signed [SpeedW-1:0] in_sideways,
   input  logic signed [SpeedW-1:0] in_forward,
   input  logic signed [SpeedW-1:0] in_turn,
   output logic                     out_valid,
   input  logic                     out_stall,
   output mwsm_mag_type             out_data
);

   localparam int Stages = 5;

   logic valid_ff [Stages];
   logic en [Stages];

   logic signed [SpeedW-1:0] vx_ff, vy_ff, vw_ff, vx_in, vy_in, vw_in;
   logic signed [LinW-1:0]   sx, sy;
   logic signed [LinW-1:0]   lin_ff [NumWheels];
   logic signed [LinW-1:0]   lin_in [NumWheels];
   logic signed [TurnW:0]    tf_full, tr_full;
   logic signed [TurnW-1:0]  tf_ff, tr_ff, tf_in, tr_in;
   logic signed [TurnW-1:0]  turn_sel [NumWheels];
   logic signed [SumW-1:0]   q8_ff [NumWheels];
   logic signed [SumW-1:0]   q8_in [NumWheels];
   logic signed [ProdW:0]    p_full [NumWheels];
   logic signed [ProdW-1:0]  p_ff [NumWheels];
   logic signed [ProdW-1:0]  p_in [NumWheels];
   logic [ProdW-1:0]         p_abs [NumWheels];
   mwsm_mag_type             out_ff, out_in;

   function automatic logic signed [SpeedW-1:0] clamp_sym(
      input logic signed [SpeedW-1:0] v,
      input logic [LimW-1:0]          lim
   );
      logic signed [SpeedW:0] v_x;
      logic signed [SpeedW:0] l_x;
      logic signed [SpeedW:0] nl_x;
      logic signed [SpeedW:0] r_x;
      v_x  = {v[SpeedW-1], v};
      l_x  = {2'b00, lim};
      nl_x = -l_x;
      if (v_x > l_x) begin
         r_x = l_x;
      end else if (v_x < nl_x) begin
         r_x = nl_x;
      end else begin
         r_x = v_x;
      end
      return r_x[SpeedW-1:0];
   endfunction

   // A stage moves when it is empty or when the stage after it moves.
   always_comb begin
      en[Stages-1] = !valid_ff[Stages-1] || !out_stall;
      for (int k = Stages - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = out_ff;

   always_comb begin
      vx_in = clamp_sym(in_sideways, cfg.max_sideways_speed);
      vy_in = clamp_sym(in_forward, cfg.max_forward_speed);
      vw_in = clamp_sym(in_turn, cfg.max_turn_rate);

      sx = {vx_ff[SpeedW-1], vx_ff};
      sy = {vy_ff[SpeedW-1], vy_ff};
      lin_in[0] = -sx - sy;
      lin_in[1] = -sx + sy;
      lin_in[2] = sx + sy;
      lin_in[3] = sx - sy;
      tf_full = vw_ff * $signed({1'b0, cfg.front_turn_ratio});
      tr_full = vw_ff * $signed({1'b0, cfg.rear_turn_ratio});
      tf_in = tf_full[TurnW-1:0];
      tr_in = tr_full[TurnW-1:0];

      for (int i = 0; i < NumWheels; i++) begin
         // The first half of the wheels sit at the front axle.
         turn_sel[i] = (i < NumWheels / 2) ? tf_ff : tr_ff;
         q8_in[i] = $signed({{(SumW - LinW - FracW){lin_ff[i][LinW-1]}}, lin_ff[i],
                             {FracW{1'b0}}})
                  + $signed({turn_sel[i][TurnW-1], turn_sel[i]});
         p_full[i] = q8_ff[i] * $signed({1'b0, cfg.rpm_per_speed});
         p_in[i]   = p_full[i][ProdW-1:0];
         // Truncation toward zero: drop the fraction from the magnitude.
         p_abs[i]  = p_ff[i][ProdW-1] ? -p_ff[i] : p_ff[i];
         out_in.mag[i] = p_abs[i][ProdW-2 -: MagW];
         out_in.neg[i] = p_ff[i][ProdW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Stages; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         vw_ff <= vw_in;
      end
      if (en[1]) begin
         lin_ff <= lin_in;
         tf_ff  <= tf_in;
         tr_ff  <= tr_in;
      end
      if (en[2]) begin
         q8_ff <= q8_in;
      end
      if (en[3]) begin
         p_ff <= p_in;
      end
      if (en[4]) begin
         out_ff <= out_in;
      end
   end

endmodule

### design/mwsm_prep.sv
// Middle section of the mixer: largest magnitude through a two-level registered
// tree, the limit compare and the scaling dividends. Depends on mwsm_pkg.
`timescale 1ns / 1ps

module mwsm_prep
   import mwsm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  mwsm_cfg_type    cfg,
   input  logic            in_valid,
   output logic            in_stall,
   input  mwsm_mag_type    in_data,
   output logic            out_valid,
   input  logic            out_stall,
   output mwsm_div_in_type out_data
);

   localparam int Stages = 3;

   logic valid_ff [Stages];
   logic en [Stages];

   mwsm_mag_type    a_ff, b_ff;
   logic [MagW-1:0] m01_ff, m23_ff, m01_in, m23_in;
   logic [MagW-1:0] maxabs_ff, maxabs_in;
   logic            scaled_ff, scaled_in;
   logic [NumW-1:0] prod [NumWheels];
   mwsm_div_in_type out_ff, out_in;

   always_comb begin
      en[Stages-1] = !valid_ff[Stages-1] || !out_stall;
      for (int k = Stages - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[Stages-1];
   assign out_data  = out_ff;

   always_comb begin
      m01_in = (in_data.mag[0] >= in_data.mag[1]) ? in_data.mag[0] : in_data.mag[1];
      m23_in = (in_data.mag[2] >= in_data.mag[3]) ? in_data.mag[2] : in_data.mag[3];

      maxabs_in = (m01_ff >= m23_ff) ? m01_ff : m23_ff;
      scaled_in = maxabs_in > {{(MagW - LimW){1'b0}}, cfg.max_wheel_speed};

      // Unscaled items go through the divider as mag / 1, which returns mag.
      for (int i = 0; i < NumWheels; i++) begin
         prod[i] = b_ff.mag[i] * cfg.max_wheel_speed;
         out_in.num[i] = scaled_ff ? prod[i] : {{QuotW{1'b0}}, b_ff.mag[i]};
      end
      out_in.den    = scaled_ff ? maxabs_ff : MagW'(1);
      out_in.neg    = b_ff.neg;
      out_in.scaled = scaled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Stages; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a_ff   <= in_data;
         m01_ff <= m01_in;
         m23_ff <= m23_in;
      end
      if (en[1]) begin
         b_ff      <= a_ff;
         maxabs_ff <= maxabs_in;
         scaled_ff <= scaled_in;
      end
      if (en[2]) begin
         out_ff <= out_in;
      end
   end

endmodule

### design/mwsm_div.sv
// Pipelined restoring divider for the four wheel lanes, one quotient bit per
// stage. The dividend must be below the divisor times 2**QuotW. Depends on mwsm_pkg.
`timescale 1ns / 1ps

module mwsm_div
   import mwsm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  mwsm_div_in_type  in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output mwsm_div_out_type out_data
);

   localparam int Stages = QuotW;

   logic valid_ff [Stages];
   logic en [Stages];

   // Each lane keeps a partial remainder and a word that holds the dividend
   // bits still to come on top and the quotient bits found so far below.
   logic [MagW-1:0]  rem_ff [Stages][NumWheels];
   logic [QuotW-1:0] lq_ff  [Stages][NumWheels];
   logic [MagW-1:0]  den_ff [Stages];
   logic [NumWheels-1:0] neg_ff [Stages];
   logic             scaled_ff [Stages];
   logic [NumW-1:0]  step_in [Stages][NumWheels];

   function automatic logic [NumW-1:0] div_step(
      input logic [MagW-1:0]  rem,
      input logic [QuotW-1:0] lq,
      input logic [MagW-1:0]  den
   );
      logic [MagW:0] trial;
      logic [MagW:0] diff;
      logic          ge;
      trial = {rem, lq[QuotW-1]};
      diff  = trial - {1'b0, den};
      ge    = trial >= {1'b0, den};
      return ge ? {diff[MagW-1:0], lq[QuotW-2:0], 1'b1}
                : {trial[MagW-1:0], lq[QuotW-2:0], 1'b0};
   endfunction

   always_comb begin
      en[Stages-1] = !valid_ff[Stages-1] || !out_stall;
      for (int k = Stages - 2; k >= 0; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   assign in_stall  = !en[0];
   assign out_valid = valid_ff[Stages-1];

   always_comb begin
      for (int i = 0; i < NumWheels; i++) begin
         step_in[0][i] = div_step(in_data.num[i][NumW-1:QuotW],
                                  in_data.num[i][QuotW-1:0], in_data.den);
         for (int s = 1; s < Stages; s++) begin
            step_in[s][i] = div_step(rem_ff[s-1][i], lq_ff[s-1][i], den_ff[s-1]);
         end
         out_data.quot[i] = lq_ff[Stages-1][i];
      end
      out_data.neg    = neg_ff[Stages-1];
      out_data.scaled = scaled_ff[Stages-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < Stages; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (en[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < Stages; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         den_ff[0]    <= in_data.den;
         neg_ff[0]    <= in_data.neg;
         scaled_ff[0] <= in_data.scaled;
      end
      for (int s = 1; s < Stages; s++) begin
         if (en[s]) begin
            den_ff[s]    <= den_ff[s-1];
            neg_ff[s]    <= neg_ff[s-1];
            scaled_ff[s] <= scaled_ff[s-1];
         end
      end
      for (int s = 0; s < Stages; s++) begin
         if (en[s]) begin
            for (int i = 0; i < NumWheels; i++) begin
               rem_ff[s][i] <= step_in[s][i][NumW-1:QuotW];
               lq_ff[s][i]  <= step_in[s][i][QuotW-1:0];
            end
         end
      end
   end

endmodule

### verif/tb.sv
// Self-checking testbench for mecanum_wheel_speed_mixer. It drives chassis commands and
// register writes and checks every wheel speed result against its own predictor.
// Depends on mwsm_pkg and the mecanum_wheel_speed_mixer RTL.
`timescale 1ns / 1ps

module tb
   import mwsm_pkg::*;
;

   // Number of mapped registers; a write at this index lands on an unmapped address.
   localparam int NumRegs      = 7;
   // The pipeline is 24 stages deep, so this many idle cycles after the last
   // expected result leaves every stage empty.
   localparam int SettleCycles = 30;
   localparam int PhaseItems   = 230;
   localparam int NumPhases    = 8;

   // One expected or observed result: four wheel speeds and the scaled flag.
   typedef struct packed {
      logic [NumWheels-1:0][SpeedW-1:0] wheel;
      logic                             scaled;
   } wheel_set_type;

   // Register settings that the phases of the run walk through.
   typedef enum int {
      SET_RESET,
      SET_RANDOM,
      SET_ZERO,
      SET_FULL,
      SET_UNIT_WHEEL,
      SET_TIGHT,
      SET_DEFAULTS
   } setting_kind_type;

   localparam setting_kind_type Plan [NumPhases] = '{
      SET_RESET, SET_RANDOM, SET_ZERO, SET_FULL,
      SET_UNIT_WHEEL, SET_TIGHT, SET_RANDOM, SET_DEFAULTS
   };

   // Scoreboard: keeps its own copy of the registers, works out the wheel speeds
   // of each accepted command and compares results in order.
   class wheel_scoreboard;
      logic [LimW-1:0]   side_limit, fwd_limit, turn_limit, wheel_limit;
      logic [RatioW-1:0] front_ratio, rear_ratio, rpm_ratio;
      wheel_set_type     wheel_q[$];
      int                errors;
      int                commands;
      int                scaled_count;

      function new();
         side_limit   = RstMaxSideways;
         fwd_limit    = RstMaxForward;
         turn_limit   = RstMaxTurn;
         front_ratio  = RstFrontRatio;
         rear_ratio   = RstRearRatio;
         rpm_ratio    = RstRpmRatio;
         wheel_limit  = RstMaxWheel;
         errors       = 0;
         commands     = 0;
         scaled_count = 0;
      endfunction

      function void write_register(int idx, logic [DataW-1:0] value);
         case (idx)
            REG_MAX_SIDEWAYS: side_limit  = value[LimW-1:0];
            REG_MAX_FORWARD:  fwd_limit   = value[LimW-1:0];
            REG_MAX_TURN:     turn_limit  = value[LimW-1:0];
            REG_FRONT_RATIO:  front_ratio = value[RatioW-1:0];
            REG_REAR_RATIO:   rear_ratio  = value[RatioW-1:0];
            REG_RPM_RATIO:    rpm_ratio   = value[RatioW-1:0];
            REG_MAX_WHEEL:    wheel_limit = value[LimW-1:0];
            default: ;
         endcase
      endfunction

      function longint clamp_part(logic signed [SpeedW-1:0] v, logic [LimW-1:0] lim);
         longint l;
         longint x;
         l = longint'(lim);
         x = longint'(v);
         if (x > l) return l;
         if (x < -l) return -l;
         return x;
      endfunction

      function wheel_set_type mix_command(logic signed [SpeedW-1:0] side,
                                          logic signed [SpeedW-1:0] fwd,
                                          logic signed [SpeedW-1:0] turn);
         longint        vx, vy, vw, ratio, q8, prod, maxabs, limit;
         longint        lin [NumWheels];
         longint        mag [NumWheels];
         bit            neg [NumWheels];
         wheel_set_type res;
         vx = clamp_part(side, side_limit);
         vy = clamp_part(fwd, fwd_limit);
         vw = clamp_part(turn, turn_limit);
         lin[0] = -vx - vy;
         lin[1] = -vx + vy;
         lin[2] = vx + vy;
         lin[3] = vx - vy;
         maxabs = 0;
         for (int i = 0; i < NumWheels; i++) begin
            ratio  = (i < 2) ? longint'(front_ratio) : longint'(rear_ratio);
            q8     = lin[i] * 256 + vw * ratio;
            prod   = q8 * longint'(rpm_ratio);
            neg[i] = prod < 0;
            // Q16.16 to integer rpm, truncating toward zero.
            mag[i] = (neg[i] ? -prod : prod) >> 16;
            if (mag[i] > maxabs) maxabs = mag[i];
         end
         limit = longint'(wheel_limit);
         res.scaled = maxabs > limit;
         for (int i = 0; i < NumWheels; i++) begin
            if (res.scaled) mag[i] = (mag[i] * limit) / maxabs;
            res.wheel[i] = SpeedW'(neg[i] ? -mag[i] : mag[i]);
         end
         return res;
      endfunction

      function void note_request(logic signed [SpeedW-1:0] side,
                                 logic signed [SpeedW-1:0] fwd,
                                 logic signed [SpeedW-1:0] turn);
         wheel_set_type want;
         want = mix_command(side, fwd, turn);
         wheel_q.push_back(want);
         commands++;
         if (want.scaled) scaled_count++;
      endfunction

      function void check_result(wheel_set_type got);
         wheel_set_type want;
         if (wheel_q.size() == 0) begin
            $display("%0t: result with no request outstanding, wheels %0d %0d %0d %0d",
                     $time, $signed(got.wheel[0]), $signed(got.wheel[1]),
                     $signed(got.wheel[2]), $signed(got.wheel[3]));
            errors++;
            return;
         end
         want = wheel_q.pop_front();
         for (int i = 0; i < NumWheels; i++) begin
            if (got.wheel[i] !== want.wheel[i]) begin
               $display("%0t: wheel_speed_%0d expected %0d actual %0d", $time, i,
                        $signed(want.wheel[i]), $signed(got.wheel[i]));
               errors++;
            end
         end
         if (got.scaled !== want.scaled) begin
            $display("%0t: was_scaled expected %0b actual %0b", $time,
                     want.scaled, got.scaled);
            errors++;
         end
      endfunction

      function int pending();
         return wheel_q.size();
      endfunction
   endclass

   // Every input of the block starts at a known value, reset asserted.
   logic              clock              = 1'b0;
   logic              reset              = 1'b1;
   logic              req_valid          = 1'b0;
   logic              req_stall;
   logic [SpeedW-1:0] req_sideways_speed = '0;
   logic [SpeedW-1:0] req_forward_speed  = '0;
   logic [SpeedW-1:0] req_turn_rate      = '0;
   logic              rsp_valid;
   logic              rsp_stall          = 1'b0;
   logic [SpeedW-1:0] rsp_wheel_speed_0;
   logic [SpeedW-1:0] rsp_wheel_speed_1;
   logic [SpeedW-1:0] rsp_wheel_speed_2;
   logic [SpeedW-1:0] rsp_wheel_speed_3;
   logic              rsp_was_scaled;
   logic              psel               = 1'b0;
   logic              penable            = 1'b0;
   logic              pwrite             = 1'b0;
   logic [AddrW-1:0]  paddr              = '0;
   logic [DataW-1:0]  pwdata             = '0;
   logic [DataW-1:0]  prdata;
   logic              pready;

   // Percentages of cycles in which the sender and the receiver sit idle.
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int settings_applied = 1;

   wheel_scoreboard sb = new();

   mecanum_wheel_speed_mixer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sideways_speed (req_sideways_speed),
      .req_forward_speed  (req_forward_speed),
      .req_turn_rate      (req_turn_rate),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_wheel_speed_0  (rsp_wheel_speed_0),
      .rsp_wheel_speed_1  (rsp_wheel_speed_1),
      .rsp_wheel_speed_2  (rsp_wheel_speed_2),
      .rsp_wheel_speed_3  (rsp_wheel_speed_3),
      .rsp_was_scaled     (rsp_was_scaled),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random in the proportion of the current idle regime.
   // It is driven at the clock edge, so the block sees a stable value all cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Both handshakes are sampled at the edge, before any of this edge's
   // nonblocking updates land, so the values seen are the ones the block saw.
   always @(posedge clock) begin
      wheel_set_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.wheel[0] = rsp_wheel_speed_0;
            got.wheel[1] = rsp_wheel_speed_1;
            got.wheel[2] = rsp_wheel_speed_2;
            got.wheel[3] = rsp_wheel_speed_3;
            got.scaled   = rsp_was_scaled;
            sb.check_result(got);
         end
         if (req_valid && !req_stall) begin
            sb.note_request(req_sideways_speed, req_forward_speed, req_turn_rate);
         end
      end
   end

   // Presents one request, after a random idle gap, and returns at the edge that
   // accepts it. Valid is left high so the caller can follow with the next request
   // in the same step without a second assignment to it.
   task automatic send_command(logic [SpeedW-1:0] side, logic [SpeedW-1:0] fwd,
                               logic [SpeedW-1:0] turn);
      int gap;
      gap = 0;
      while ($urandom_range(99) < tx_idle_pct && gap < 20) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_sideways_speed <= side;
      req_forward_speed  <= fwd;
      req_turn_rate      <= turn;
      do @(posedge clock); while (req_stall);
   endtask

   // Stops sending and waits until every expected result has been taken, then
   // lets the pipeline run empty before anything else happens.
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   // One APB write: setup cycle, then access cycle until pready. A spare idle
   // cycle at the end keeps back-to-back writes from touching psel twice per step.
   task automatic csr_write(int idx, logic [DataW-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= AddrW'(4 * idx);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.write_register(idx, value);
      @(posedge clock);
   endtask

   // Writes a full register setting. Values are written as whole 32-bit words, so
   // bits above a register's width go out too and must be dropped by the block.
   task automatic apply_setting(setting_kind_type kind);
      logic [DataW-1:0] vals [NumRegs];
      case (kind)
         SET_RANDOM: begin
            foreach (vals[i]) vals[i] = $urandom();
         end
         SET_ZERO: begin
            // Zero clamp limits force every part to zero; a zero wheel limit
            // scales any nonzero speed down to zero.
            foreach (vals[i]) vals[i] = '0;
         end
         SET_FULL: begin
            foreach (vals[i]) vals[i] = '1;
         end
         SET_UNIT_WHEEL: begin
            vals[REG_MAX_SIDEWAYS] = $urandom_range(32767);
            vals[REG_MAX_FORWARD]  = $urandom_range(32767);
            vals[REG_MAX_TURN]     = $urandom_range(32767);
            vals[REG_FRONT_RATIO]  = $urandom_range(65535);
            vals[REG_REAR_RATIO]   = $urandom_range(65535);
            vals[REG_RPM_RATIO]    = $urandom_range(65535);
            vals[REG_MAX_WHEEL]    = 1;
         end
         SET_TIGHT: begin
            vals[REG_MAX_SIDEWAYS] = $urandom_range(60, 1);
            vals[REG_MAX_FORWARD]  = $urandom_range(60, 1);
            vals[REG_MAX_TURN]     = $urandom_range(60, 1);
            vals[REG_FRONT_RATIO]  = $urandom_range(65535, 32768);
            vals[REG_REAR_RATIO]   = $urandom_range(65535, 32768);
            vals[REG_RPM_RATIO]    = $urandom_range(65535);
            vals[REG_MAX_WHEEL]    = $urandom_range(32767, 1);
         end
         default: begin
            vals[REG_MAX_SIDEWAYS] = RstMaxSideways;
            vals[REG_MAX_FORWARD]  = RstMaxForward;
            vals[REG_MAX_TURN]     = RstMaxTurn;
            vals[REG_FRONT_RATIO]  = RstFrontRatio;
            vals[REG_REAR_RATIO]   = RstRearRatio;
            vals[REG_RPM_RATIO]    = RstRpmRatio;
            vals[REG_MAX_WHEEL]    = RstMaxWheel;
         end
      endcase
      for (int i = 0; i < NumRegs; i++) csr_write(i, vals[i]);
      // A write past the last register must leave every register alone.
      if (kind == SET_RANDOM || kind == SET_DEFAULTS) csr_write(NumRegs, $urandom());
      settings_applied++;
   endtask

   // Draws one command part around its clamp limit: full-range noise, values a
   // little past the limit, the exact boundaries, and values inside the limit.
   function automatic logic [SpeedW-1:0] pick_speed(int lim);
      int span;
      case ($urandom_range(9))
         0, 1, 2: return SpeedW'($urandom());
         3, 4: begin
            span = lim + lim / 2 + 1;
            return SpeedW'(int'($urandom_range(2 * span)) - span);
         end
         5: begin
            case ($urandom_range(6))
               0:       return SpeedW'(lim);
               1:       return SpeedW'(-lim);
               2:       return SpeedW'(lim + 1);
               3:       return SpeedW'(-lim - 1);
               4:       return SpeedW'(32767);
               5:       return SpeedW'(-32768);
               default: return '0;
            endcase
         end
         default: return SpeedW'(int'($urandom_range(2 * lim)) - lim);
      endcase
   endfunction

   // Fixed commands under the reset setting: zero, each part alone at its limit, all
   // parts just past their limits, the field extremes, and a mix that needs scaling.
   task automatic run_directed();
      send_command(16'sd0, 16'sd0, 16'sd0);
      send_command(16'sd500, 16'sd0, 16'sd0);
      send_command(-16'sd500, 16'sd0, 16'sd0);
      send_command(16'sd0, 16'sd500, 16'sd0);
      send_command(16'sd0, -16'sd500, 16'sd0);
      send_command(16'sd0, 16'sd0, 16'sd200);
      send_command(16'sd0, 16'sd0, -16'sd200);
      send_command(16'sd501, 16'sd501, 16'sd201);
      send_command(-16'sd501, -16'sd501, -16'sd201);
      send_command(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_command(16'sh8000, 16'sh8000, 16'sh8000);
      send_command(16'sh7FFF, 16'sh8000, 16'sd0);
      send_command(16'sh8000, 16'sh7FFF, 16'sh7FFF);
      send_command(16'sd500, 16'sd500, 16'sd0);
      send_command(16'sd250, -16'sd250, 16'sd100);
   endtask

   // Main sequence. Each phase after the first loads a register setting while the
   // block is empty; every phase streams random commands drawn around the active
   // limits, and halfway through it holds off until all results are back.
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < NumPhases; phase++) begin
         // Idle regimes: sender light and receiver heavy, then swapped, then none.
         if (phase < 3) begin
            tx_idle_pct = 30;
            rx_idle_pct = 59;
         end else if (phase < 6) begin
            tx_idle_pct = 59;
            rx_idle_pct = 30;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if (phase > 0) begin
            drain_pipeline();
            apply_setting(Plan[phase]);
         end else begin
            run_directed();
         end
         for (int n = 0; n < PhaseItems; n++) begin
            if (n == PhaseItems / 2) drain_pipeline();
            send_command(pick_speed(int'(sb.side_limit)),
                         pick_speed(int'(sb.fwd_limit)),
                         pick_speed(int'(sb.turn_limit)));
         end
      end
      drain_pipeline();
      $display("Covered %0d commands under %0d register settings; %0d of them were scaled.",
               sb.commands, settings_applied, sb.scaled_count);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("mecanum_wheel_speed_mixer regression: pass");
      end else begin
         $display("mecanum_wheel_speed_mixer regression: fail");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #5_000_000;
      $display("mecanum_wheel_speed_mixer regression: fail");
      $finish;
   end

endmodule
